// File: design/imhos_pkg.sv
package imhos_pkg;

	localparam int HEAP_CAPACITY = 256;
	localparam int NODE_COUNT    = 256;
	localparam int COST_BITS     = 32;
	localparam int SLOT_W        = $clog2(HEAP_CAPACITY);
	localparam int CNT_W         = SLOT_W + 1;
	localparam int ID_W          = 8;
	localparam int NADDR_W       = $clog2(NODE_COUNT);
	localparam int F_W           = COST_BITS + 1;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_PEEK   = 3'd1;
	localparam logic [2:0] OP_POP    = 3'd2;
	localparam logic [2:0] OP_CHANGE = 3'd3;
	localparam logic [2:0] OP_EXISTS = 3'd4;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_EMPTY      = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_NOT_QUEUED = 3'd3;
	localparam logic [2:0] ST_QUEUED     = 3'd4;

	typedef logic [COST_BITS-1:0] cost_t;
	typedef logic [F_W-1:0] fcost_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  node_id;
		logic [31:0] cost_g;
		logic [31:0] cost_h;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_node;
		logic [31:0] out_g;
		logic [31:0] out_h;
		logic        present;
	} rsp_t;

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_DECODE   = 14'b00000000000010,
		S_TOP      = 14'b00000000000100,
		S_POP_LAST = 14'b00000000001000,
		S_POP_LG   = 14'b00000000010000,
		S_UP_CHK   = 14'b00000000100000,
		S_UP_RDP   = 14'b00000001000000,
		S_UP_CMP   = 14'b00000010000000,
		S_DN_CHK   = 14'b00000100000000,
		S_DN_RDL   = 14'b00001000000000,
		S_DN_GL    = 14'b00010000000000,
		S_DN_GR    = 14'b00100000000000,
		S_DN_CMP   = 14'b01000000000000,
		S_WR_CUR   = 14'b10000000000000
	} state_t;

	typedef struct packed {
		state_t step;
		logic   accept;
	} cmd_t;

	typedef struct packed {
		logic is_add;
		logic is_peek;
		logic is_pop;
		logic is_change;
		logic err;
		logic up_dir;
		logic last_one;
		logic pos_zero;
		logic left_out;
		logic right_in;
		logic up_win;
		logic child_win;
	} stat_t;

	function automatic fcost_t f_of(cost_t g, cost_t h);
		return {1'b0, g} + {1'b0, h};
	endfunction

	function automatic logic ranks_before(fcost_t fa, cost_t ha, fcost_t fb, cost_t hb);
		return (fa < fb) || ((fa == fb) && (ha < hb));
	endfunction

endpackage

// File: design/imhos_ctrl.sv
module imhos_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  imhos_pkg::stat_t st,
	output imhos_pkg::cmd_t  cmd,
	output logic             busy
);

	imhos_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imhos_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imhos_pkg::S_IDLE: begin
				if (start) state_d = imhos_pkg::S_DECODE;
			end
			imhos_pkg::S_DECODE: begin
				if (st.err) state_d = imhos_pkg::S_IDLE;
				else if (st.is_peek || st.is_pop) state_d = imhos_pkg::S_TOP;
				else if (st.is_add) state_d = imhos_pkg::S_UP_CHK;
				else if (st.is_change) state_d = st.up_dir ? imhos_pkg::S_UP_CHK
				                                           : imhos_pkg::S_DN_CHK;
				else state_d = imhos_pkg::S_IDLE;
			end
			imhos_pkg::S_TOP: begin
				if (st.is_pop && !st.last_one) state_d = imhos_pkg::S_POP_LAST;
				else state_d = imhos_pkg::S_IDLE;
			end
			imhos_pkg::S_POP_LAST: state_d = imhos_pkg::S_POP_LG;
			imhos_pkg::S_POP_LG:   state_d = imhos_pkg::S_DN_CHK;
			imhos_pkg::S_UP_CHK:
				state_d = st.pos_zero ? imhos_pkg::S_WR_CUR : imhos_pkg::S_UP_RDP;
			imhos_pkg::S_UP_RDP:   state_d = imhos_pkg::S_UP_CMP;
			imhos_pkg::S_UP_CMP:
				state_d = st.up_win ? imhos_pkg::S_UP_CHK : imhos_pkg::S_WR_CUR;
			imhos_pkg::S_DN_CHK:
				state_d = st.left_out ? imhos_pkg::S_WR_CUR : imhos_pkg::S_DN_RDL;
			imhos_pkg::S_DN_RDL:   state_d = imhos_pkg::S_DN_GL;
			imhos_pkg::S_DN_GL:
				state_d = st.right_in ? imhos_pkg::S_DN_GR : imhos_pkg::S_DN_CMP;
			imhos_pkg::S_DN_GR:    state_d = imhos_pkg::S_DN_CMP;
			imhos_pkg::S_DN_CMP:
				state_d = st.child_win ? imhos_pkg::S_DN_CHK : imhos_pkg::S_WR_CUR;
			imhos_pkg::S_WR_CUR:   state_d = imhos_pkg::S_IDLE;
			default:               state_d = imhos_pkg::S_IDLE;
		endcase
	end

	assign busy       = (state_q != imhos_pkg::S_IDLE);
	assign cmd.step   = state_q;
	assign cmd.accept = start && (state_q == imhos_pkg::S_IDLE);

endmodule

// File: design/imhos_dp.sv
module imhos_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  imhos_pkg::cmd_t  cmd,
	input  imhos_pkg::req_t  req,
	output imhos_pkg::stat_t st,
	output imhos_pkg::rsp_t  rsp,
	output logic             done
);

	localparam int SW = imhos_pkg::SLOT_W;
	localparam int CW = imhos_pkg::CNT_W;
	localparam int NW = imhos_pkg::NADDR_W;

	// storage
	logic [imhos_pkg::ID_W-1:0] slot_mem [imhos_pkg::HEAP_CAPACITY];
	imhos_pkg::cost_t           g_mem    [imhos_pkg::NODE_COUNT];
	imhos_pkg::cost_t           h_mem    [imhos_pkg::NODE_COUNT];
	logic [SW-1:0]              map_mem  [imhos_pkg::NODE_COUNT];
	logic [imhos_pkg::NODE_COUNT-1:0] valid_q;

	logic [imhos_pkg::ID_W-1:0] slot_rd;
	imhos_pkg::cost_t           g_rd, h_rd;
	logic [SW-1:0]              map_rd;

	logic [2:0]                 op_q;
	logic [imhos_pkg::ID_W-1:0] id_q;
	imhos_pkg::cost_t           ing_q, inh_q;
	logic [CW-1:0]              count_q;
	logic [SW-1:0]              pos_q;
	logic [imhos_pkg::ID_W-1:0] cur_node_q, nb_node_q, r_node_q, ch_node_q, top_node_q;
	imhos_pkg::cost_t           cur_h_q, ch_h_q;
	imhos_pkg::fcost_t          cur_f_q, ch_f_q;
	logic [SW-1:0]              ch_pos_q;
	imhos_pkg::rsp_t            rsp_q;
	imhos_pkg::rsp_t            dec_rsp;
	logic                       done_q;

	logic [SW-1:0]              slot_ra, slot_wa;
	logic [imhos_pkg::ID_W-1:0] slot_wd;
	logic                       slot_we;
	logic [imhos_pkg::ID_W-1:0] node_ra;
	logic                       cost_we;
	logic [imhos_pkg::ID_W-1:0] map_wa;
	logic                       map_we;

	logic [SW-1:0]   par;
	logic [CW:0]     lft, rgt;
	imhos_pkg::fcost_t rd_f, in_f;
	logic            id_valid;
	logic            is_ok_add, is_ok_change;

	assign par      = SW'((pos_q - SW'(1)) >> 1);
	assign lft      = {1'b0, pos_q, 1'b1};
	assign rgt      = lft + (CW+1)'(1);
	assign rd_f     = imhos_pkg::f_of(g_rd, h_rd);
	assign in_f     = imhos_pkg::f_of(ing_q, inh_q);
	assign id_valid = valid_q[NW'(id_q)];

	always_comb begin
		st.is_add    = (op_q == imhos_pkg::OP_ADD);
		st.is_peek   = (op_q == imhos_pkg::OP_PEEK);
		st.is_pop    = (op_q == imhos_pkg::OP_POP);
		st.is_change = (op_q == imhos_pkg::OP_CHANGE);
		st.err       = (st.is_add && (id_valid || count_q == CW'(imhos_pkg::HEAP_CAPACITY)))
		            || ((st.is_peek || st.is_pop) && count_q == '0)
		            || (st.is_change && !id_valid);
		st.up_dir    = in_f < rd_f;
		st.last_one  = (count_q == CW'(1));
		st.pos_zero  = (pos_q == '0);
		st.left_out  = (lft >= {1'b0, count_q});
		st.right_in  = (rgt < {1'b0, count_q});
		st.up_win    = imhos_pkg::ranks_before(cur_f_q, cur_h_q, rd_f, h_rd);
		st.child_win = imhos_pkg::ranks_before(ch_f_q, ch_h_q, cur_f_q, cur_h_q);
	end

	assign is_ok_add    = (cmd.step == imhos_pkg::S_DECODE) && st.is_add && !st.err;
	assign is_ok_change = (cmd.step == imhos_pkg::S_DECODE) && st.is_change && !st.err;

	always_comb begin
		dec_rsp = '0;
		if (st.err) begin
			if (st.is_add)
				dec_rsp.status = id_valid ? imhos_pkg::ST_QUEUED : imhos_pkg::ST_FULL;
			else if (st.is_change)
				dec_rsp.status = imhos_pkg::ST_NOT_QUEUED;
			else
				dec_rsp.status = imhos_pkg::ST_EMPTY;
		end
		dec_rsp.present = (op_q == imhos_pkg::OP_EXISTS) && id_valid;
	end

	// memory address selection
	always_comb begin
		slot_ra = '0;
		node_ra = req.node_id;
		slot_we = 1'b0;
		slot_wa = pos_q;
		slot_wd = cur_node_q;
		map_we  = 1'b0;
		map_wa  = cur_node_q;
		cost_we = is_ok_add || is_ok_change;
		unique case (cmd.step)
			imhos_pkg::S_DECODE: node_ra = cost_we ? id_q : slot_rd;
			imhos_pkg::S_TOP:    slot_ra = SW'(count_q - CW'(1));
			imhos_pkg::S_POP_LAST: node_ra = slot_rd;
			imhos_pkg::S_UP_CHK: slot_ra = par;
			imhos_pkg::S_UP_RDP: node_ra = slot_rd;
			imhos_pkg::S_UP_CMP: begin
				slot_wd = nb_node_q;
				map_wa  = nb_node_q;
				slot_we = st.up_win;
				map_we  = st.up_win;
			end
			imhos_pkg::S_DN_CHK: slot_ra = SW'(lft);
			imhos_pkg::S_DN_RDL: begin
				node_ra = slot_rd;
				slot_ra = SW'(rgt);
			end
			imhos_pkg::S_DN_GL:  node_ra = slot_rd;
			imhos_pkg::S_DN_CMP: begin
				slot_wd = ch_node_q;
				map_wa  = ch_node_q;
				slot_we = st.child_win;
				map_we  = st.child_win;
			end
			imhos_pkg::S_WR_CUR: begin
				slot_we = 1'b1;
				map_we  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd <= slot_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (cost_we) begin
			g_mem[NW'(id_q)] <= ing_q;
			h_mem[NW'(id_q)] <= inh_q;
		end
		g_rd <= g_mem[NW'(node_ra)];
		h_rd <= h_mem[NW'(node_ra)];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[NW'(map_wa)] <= pos_q;
		map_rd <= map_mem[NW'(req.node_id)];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (cmd.step == imhos_pkg::S_TOP)
			       || (cmd.step == imhos_pkg::S_DECODE && (st.err || !(st.is_peek || st.is_pop)));
			if (is_ok_add) begin
				valid_q[NW'(id_q)] <= 1'b1;
				count_q <= count_q + CW'(1);
			end
			if (cmd.step == imhos_pkg::S_TOP && st.is_pop) begin
				valid_q[NW'(top_node_q)] <= 1'b0;
				count_q <= count_q - CW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= req.opcode;
			id_q  <= req.node_id;
			ing_q <= imhos_pkg::cost_t'(req.cost_g);
			inh_q <= imhos_pkg::cost_t'(req.cost_h);
		end
		unique case (cmd.step)
			imhos_pkg::S_DECODE: begin
				top_node_q <= slot_rd;
				cur_node_q <= id_q;
				cur_h_q    <= inh_q;
				cur_f_q    <= in_f;
				pos_q      <= st.is_add ? SW'(count_q) : map_rd;
				rsp_q      <= dec_rsp;
			end
			imhos_pkg::S_TOP: begin
				rsp_q.status   <= imhos_pkg::ST_OK;
				rsp_q.out_node <= top_node_q;
				rsp_q.out_g    <= 32'(g_rd);
				rsp_q.out_h    <= 32'(h_rd);
				rsp_q.present  <= 1'b0;
			end
			imhos_pkg::S_POP_LAST: cur_node_q <= slot_rd;
			imhos_pkg::S_POP_LG: begin
				cur_h_q <= h_rd;
				cur_f_q <= rd_f;
				pos_q   <= '0;
			end
			imhos_pkg::S_UP_RDP: nb_node_q <= slot_rd;
			imhos_pkg::S_UP_CMP: if (st.up_win) pos_q <= par;
			imhos_pkg::S_DN_RDL: nb_node_q <= slot_rd;
			imhos_pkg::S_DN_GL: begin
				ch_node_q <= nb_node_q;
				ch_f_q    <= rd_f;
				ch_h_q    <= h_rd;
				ch_pos_q  <= SW'(lft);
				r_node_q  <= slot_rd;
			end
			imhos_pkg::S_DN_GR: begin
				if (imhos_pkg::ranks_before(rd_f, h_rd, ch_f_q, ch_h_q)) begin
					ch_node_q <= r_node_q;
					ch_f_q    <= rd_f;
					ch_h_q    <= h_rd;
					ch_pos_q  <= SW'(rgt);
				end
			end
			imhos_pkg::S_DN_CMP: if (st.child_win) pos_q <= ch_pos_q;
			default: ;
		endcase
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

// File: design/indexed_min_heap_astar_open_set.sv
// Indexed binary min-heap, open set of an A* search.
// Request channel: drive req (opcode, node_id, cost_g, cost_h) and pulse
// start; the transaction is taken at a rising edge with start high and busy
// low. busy stays high until the heap has settled.
// Result channel: done is high for exactly one cycle with rsp (status,
// out_node, out_g, out_h, present). The receiver cannot stall; every request
// gives exactly one result, which is not held.
// The result is registered in the decode step (the top step for peek/pop).
// Exists, peek and rejected requests end with no heap walk; add and change
// walk the heap level by level, up (check, read parent, compare) or down
// (check, read left, get left, get right if present, compare), then a final
// write; pop reads the last entry and its costs before its sift down. The
// single slot read port and shared cost memory read set the walk's pace.
// Reset: asynchronous, active low; the heap is empty and no node is queued
// immediately after reset, with no clearing pass.
module indexed_min_heap_astar_open_set (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  imhos_pkg::req_t req,
	output logic            done,
	output imhos_pkg::rsp_t rsp
);

	imhos_pkg::cmd_t  cmd;
	imhos_pkg::stat_t st;

	imhos_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	imhos_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.st     (st),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

// File: design/imhos_chk.sv
module imhos_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input imhos_pkg::rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after transaction");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status <= imhos_pkg::ST_QUEUED))
		else $error("status code out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != imhos_pkg::ST_OK) |->
		(rsp.out_node == '0 && rsp.out_g == '0 && rsp.out_h == '0 && !rsp.present))
		else $error("payload set on rejected request");

	a_present_no_node: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.present) |-> (rsp.out_node == '0 && rsp.out_g == '0))
		else $error("exists answer mixed with top node");

endmodule

bind indexed_min_heap_astar_open_set imhos_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
